// ===== sv/ddlb_pkg.sv =====
// Shared types and constants for the delimited decimal list parser.
package ddlb_pkg;

   localparam int MAX_FIELD_CHARS = 32;
   localparam int FIELD_LEN_W     = $clog2(MAX_FIELD_CHARS + 1);
   localparam int CHAR_W          = 8;
   localparam int COUNT_W         = 8;
   localparam int CSR_INDEX_W     = 1;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_INDEX_W-1:0] CSR_DELIMITER  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VALUES = 1'b1;

   localparam logic [CHAR_W-1:0]  DELIMITER_RESET  = 8'd44;
   localparam logic [COUNT_W-1:0] MAX_VALUES_RESET = 8'd255;

   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

   typedef enum logic [1:0] {
      KIND_CHAR,
      KIND_DELIM,
      KIND_END
   } kind_type;

   typedef enum logic [1:0] {
      PH_WS,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   typedef struct packed {
      kind_type          kind;
      logic [CHAR_W-1:0] char_code;
   } item_type;

endpackage

// ===== sv/ddlb_ifs.sv =====
// Channel interfaces: character input, result output and register write.
interface ddlb_req_if import ddlb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              end_of_string;

   modport source (output valid, output char_code, output end_of_string, input ready);
   modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface ddlb_rsp_if import ddlb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CHAR_W-1:0]  value;
   logic               value_present;
   logic [COUNT_W-1:0] values_so_far;
   logic               is_final;

   modport source (output valid, output value, output value_present,
                   output values_so_far, output is_final, input ready);
   modport sink   (input valid, input value, input value_present,
                   input values_so_far, input is_final, output ready);
endinterface

interface ddlb_csr_if import ddlb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CHAR_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/ddlb_front.sv =====
// Front end: takes input words and tags each as character, delimiter or end.
module ddlb_front import ddlb_pkg::*; (
   ddlb_req_if.sink          req_chan,
   input  logic [CHAR_W-1:0] delimiter,
   output logic              push_valid,
   output item_type          push_item,
   input  logic              push_ready
);

   always_comb begin
      push_item.char_code = req_chan.char_code;
      priority if (req_chan.end_of_string) begin
         push_item.kind = KIND_END;
      end else if (req_chan.char_code == delimiter) begin
         push_item.kind = KIND_DELIM;
      end else begin
         push_item.kind = KIND_CHAR;
      end
   end

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

endmodule

// ===== sv/ddlb_queue.sv =====
// Short queue of tagged words between the front and back ends.
module ddlb_queue import ddlb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     push_ready,
   output logic     pop_valid,
   output item_type pop_item,
   input  logic     pop_ready
);

   item_type               store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   push, pop;

   assign push_ready = (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = store_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/ddlb_back.sv =====
// Back end: field conversion, emit decision and the result register.
module ddlb_back import ddlb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [COUNT_W-1:0] max_values,
   input  logic               pop_valid,
   input  item_type           pop_item,
   output logic               pop_ready,
   ddlb_rsp_if.source         rsp_chan
);

   logic [FIELD_LEN_W-1:0] len_ff, len_in;
   phase_type              phase_ff, phase_in;
   logic                   neg_ff, neg_in;
   logic [CHAR_W-1:0]      acc_ff, acc_in;
   logic [COUNT_W-1:0]     count_ff, count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      value_ff, value_in;
   logic                   present_ff, present_in;
   logic [COUNT_W-1:0]     so_far_ff, so_far_in;
   logic                   final_ff, final_in;

   logic                   slot_free, take, emits, digit, space;
   logic [CHAR_W-1:0]      c, digit_val, field_val;
   logic [COUNT_W-1:0]     count_inc;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   // plain characters never produce a result, so they drain even while output stalls
   assign pop_ready = (pop_item.kind == KIND_CHAR) || slot_free;
   assign take      = pop_valid && pop_ready;

   assign c         = pop_item.char_code;
   assign digit     = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign space     = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   assign digit_val = c - CHAR_ZERO;
   assign emits     = (count_ff < max_values) && (len_ff != '0) &&
                      (len_ff < FIELD_LEN_W'(MAX_FIELD_CHARS));
   assign field_val = neg_ff ? (8'd0 - acc_ff) : acc_ff;
   assign count_inc = count_ff + 1'b1;

   always_comb begin
      len_in       = len_ff;
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_chan.ready ? 1'b0 : rsp_valid_ff;
      value_in     = value_ff;
      present_in   = present_ff;
      so_far_in    = so_far_ff;
      final_in     = final_ff;

      if (take) begin
         unique case (pop_item.kind)
            KIND_END: begin
               rsp_valid_in = 1'b1;
               value_in     = emits ? field_val : '0;
               present_in   = emits;
               so_far_in    = emits ? count_inc : count_ff;
               final_in     = 1'b1;
               len_in       = '0;
               phase_in     = PH_WS;
               neg_in       = 1'b0;
               acc_in       = '0;
               count_in     = '0;
            end
            KIND_DELIM: begin
               if (emits) begin
                  rsp_valid_in = 1'b1;
                  value_in     = field_val;
                  present_in   = 1'b1;
                  so_far_in    = count_inc;
                  final_in     = 1'b0;
                  count_in     = count_inc;
               end
               len_in   = '0;
               phase_in = PH_WS;
               neg_in   = 1'b0;
               acc_in   = '0;
            end
            default: begin
               if (len_ff < FIELD_LEN_W'(MAX_FIELD_CHARS)) begin
                  len_in = len_ff + 1'b1;
                  // convert only the first MAX_FIELD_CHARS-1 characters
                  if (len_ff < FIELD_LEN_W'(MAX_FIELD_CHARS - 1)) begin
                     unique case (phase_ff)
                        PH_WS: begin
                           priority if (space) begin
                              phase_in = PH_WS;
                           end else if (c == CHAR_PLUS) begin
                              phase_in = PH_DIGITS;
                           end else if (c == CHAR_MINUS) begin
                              neg_in   = 1'b1;
                              phase_in = PH_DIGITS;
                           end else if (digit) begin
                              acc_in   = digit_val;
                              phase_in = PH_DIGITS;
                           end else begin
                              phase_in = PH_DONE;
                           end
                        end
                        PH_DIGITS: begin
                           if (digit) begin
                              acc_in = {acc_ff[4:0], 3'b000} + {acc_ff[6:0], 1'b0} +
                                       digit_val;
                           end else begin
                              phase_in = PH_DONE;
                           end
                        end
                        default: begin
                           phase_in = phase_ff;
                        end
                     endcase
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         phase_ff     <= PH_WS;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      present_ff <= present_in;
      so_far_ff  <= so_far_in;
      final_ff   <= final_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.value         = value_ff;
   assign rsp_chan.value_present = present_ff;
   assign rsp_chan.values_so_far = so_far_ff;
   assign rsp_chan.is_final      = final_ff;

endmodule

// ===== sv/delimited_decimal_list_to_bytes_unit.sv =====
// Top level of the delimited decimal list parser: registers, front, queue, back.
//
//   channel    dir  payload                                          accepted when
//   req_chan   in   char_code[8], end_of_string                      valid && ready
//   rsp_chan   out  value[8], value_present, values_so_far[8], is_final  valid && ready
//   csr_chan   in   index[1] (0 delimiter, 1 max_values), data[8]    valid (ready stays high)
//
// One character word per cycle sustained while no result stall holds a delimiter or
// end word; a taken word is written into a queue slot, then popped by the back end,
// whose update loads the result register.
// Reset clears the field state, the count, the queue and the output valid, and
// loads delimiter 44 and max_values 255. A stalled result stalls only delimiter and
// end words; characters keep draining, and the two-entry queue absorbs short stalls.
module delimited_decimal_list_to_bytes_unit import ddlb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ddlb_req_if.sink    req_chan,
   ddlb_rsp_if.source  rsp_chan,
   ddlb_csr_if.sink    csr_chan
);

   logic [CHAR_W-1:0]  delimiter_ff, delimiter_in;
   logic [COUNT_W-1:0] max_values_ff, max_values_in;

   logic     push_valid, push_ready, pop_valid, pop_ready;
   item_type push_item, pop_item;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      delimiter_in  = delimiter_ff;
      max_values_in = max_values_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_DELIMITER:  delimiter_in  = csr_chan.data;
            CSR_MAX_VALUES: max_values_in = csr_chan.data;
            default:        delimiter_in  = delimiter_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff  <= DELIMITER_RESET;
         max_values_ff <= MAX_VALUES_RESET;
      end else begin
         delimiter_ff  <= delimiter_in;
         max_values_ff <= max_values_in;
      end
   end

   ddlb_front u_front (
      .req_chan   (req_chan),
      .delimiter  (delimiter_ff),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   ddlb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   ddlb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .max_values (max_values_ff),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule
